/* rtl/srm_pkg.sv */
// ----------------------------------------------------------------------------
// srm_pkg: shared types and constants of the sparse table range minimum unit
// Request and result layouts, request codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package srm_pkg;

  localparam int NUM_ELEMENTS_DEF = 1024;
  localparam int NUM_LEVELS_DEF   = 11;

  localparam int FIELD_IDX_W = 10;
  localparam int VALUE_W     = 32;
  localparam int LEN_W       = FIELD_IDX_W + 1;
  localparam int LOG_W       = 4;

  localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_BUILD = 2'd2,
    REQ_QUERY = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t                 req_type;
    logic [FIELD_IDX_W-1:0]    element_index;
    logic signed [VALUE_W-1:0] element_value;
    logic [FIELD_IDX_W-1:0]    left_bound;
    logic [FIELD_IDX_W-1:0]    right_bound;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] min_value;
    logic                      bad_range;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BLD_A,
    ST_BLD_B,
    ST_BLD_W,
    ST_Q_LVL,
    ST_Q_A,
    ST_Q_B,
    ST_Q_MIN,
    ST_OUT
  } state_t;

  function automatic logic [LOG_W-1:0] floor_log2_len(input logic [LEN_W-1:0] v);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int k = 1; k < LEN_W; k++) begin
      if (v[k]) begin
        r = LOG_W'(k);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/sparse_table_range_min_unit.sv */
// Query: Q_LVL, Q_A, Q_B, Q_MIN, then OUT passes the result to the output
// register (inverted or out-of-range: straight to OUT); the next request is
// taken once the result moves on. Load: written on acceptance. Build: BLD_A,
// BLD_B, BLD_W per entry, (NUM_LEVELS-1)*NUM_ELEMENTS entries. Clear: one entry
// per cycle. After reset the same sweep runs before the first request is taken.
// ----------------------------------------------------------------------------
// sparse_table_range_min_unit: sparse table range minimum engine
// Sequencer and level store with a registered result output.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_table_range_min_unit #(
  parameter int NUM_ELEMENTS = srm_pkg::NUM_ELEMENTS_DEF,
  parameter int NUM_LEVELS   = srm_pkg::NUM_LEVELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire srm_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output srm_pkg::out_item_t      out_data
);

  localparam int ADDR_W = $clog2(NUM_LEVELS) + $clog2(NUM_ELEMENTS);

  logic                               res_valid;
  logic                               res_taken;
  srm_pkg::out_item_t                 res_data;
  logic                               mem_wr_en;
  logic [ADDR_W-1:0]                  mem_wr_addr;
  logic signed [srm_pkg::VALUE_W-1:0] mem_wr_data;
  logic [ADDR_W-1:0]                  mem_rd_addr;
  logic signed [srm_pkg::VALUE_W-1:0] mem_rd_data;

  logic                               out_valid_r, out_valid_nxt;
  srm_pkg::out_item_t                 out_data_r, out_data_nxt;

  srm_seq #(
    .NUM_ELEMENTS (NUM_ELEMENTS),
    .NUM_LEVELS   (NUM_LEVELS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_taken   (res_taken),
    .res_data    (res_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  srm_level_mem #(
    .NUM_ELEMENTS (NUM_ELEMENTS),
    .NUM_LEVELS   (NUM_LEVELS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_taken = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_taken) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* rtl/srm_level_mem.sv */
// ----------------------------------------------------------------------------
// srm_level_mem: level store of the sparse table
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_level_mem #(
  parameter int NUM_ELEMENTS = srm_pkg::NUM_ELEMENTS_DEF,
  parameter int NUM_LEVELS   = srm_pkg::NUM_LEVELS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [$clog2(NUM_LEVELS)+$clog2(NUM_ELEMENTS)-1:0] wr_addr,
  input  wire logic signed [srm_pkg::VALUE_W-1:0]    wr_data,
  input  wire logic [$clog2(NUM_LEVELS)+$clog2(NUM_ELEMENTS)-1:0] rd_addr,
  output logic signed [srm_pkg::VALUE_W-1:0]         rd_data
);

  localparam int IDX_W = $clog2(NUM_ELEMENTS);
  localparam int DEPTH = NUM_LEVELS * (2 ** IDX_W);

  logic signed [srm_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/srm_seq.sv */
// ----------------------------------------------------------------------------
// srm_seq: request sequencer of the sparse table range minimum unit
// Runs the clearing sweep, element loads, the level build and range queries
// against the level store.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_seq #(
  parameter int NUM_ELEMENTS = srm_pkg::NUM_ELEMENTS_DEF,
  parameter int NUM_LEVELS   = srm_pkg::NUM_LEVELS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire srm_pkg::in_item_t                     in_data,
  output logic                                       res_valid,
  input  wire logic                                  res_taken,
  output srm_pkg::out_item_t                         res_data,
  output logic                                       mem_wr_en,
  output logic [$clog2(NUM_LEVELS)+$clog2(NUM_ELEMENTS)-1:0] mem_wr_addr,
  output logic signed [srm_pkg::VALUE_W-1:0]         mem_wr_data,
  output logic [$clog2(NUM_LEVELS)+$clog2(NUM_ELEMENTS)-1:0] mem_rd_addr,
  input  wire logic signed [srm_pkg::VALUE_W-1:0]    mem_rd_data
);

  localparam int IDX_W  = $clog2(NUM_ELEMENTS);
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int ADDR_W = LVL_W + IDX_W;
  localparam int DEPTH  = NUM_LEVELS * (2 ** IDX_W);
  localparam int CMP_W  = (IDX_W > srm_pkg::FIELD_IDX_W ? IDX_W : srm_pkg::FIELD_IDX_W) + 1;
  localparam int NXT_W  = (IDX_W > NUM_LEVELS - 2 ? IDX_W : NUM_LEVELS - 2) + 1;

  srm_pkg::state_t                    state_r, state_nxt;
  logic [ADDR_W-1:0]                  clr_addr_r, clr_addr_nxt;
  logic [LVL_W-1:0]                   lvl_r, lvl_nxt;
  logic [IDX_W-1:0]                   idx_r, idx_nxt;
  logic [srm_pkg::FIELD_IDX_W-1:0]    lt_r, lt_nxt;
  logic [srm_pkg::FIELD_IDX_W-1:0]    rt_r, rt_nxt;
  logic [CMP_W-1:0]                   rtc_r, rtc_nxt;
  logic [IDX_W-1:0]                   sec_r, sec_nxt;
  logic signed [srm_pkg::VALUE_W-1:0] a_r, a_nxt;
  logic                               b_oob_r, b_oob_nxt;
  srm_pkg::out_item_t                 res_r, res_nxt;

  logic                               accept;
  logic [CMP_W-1:0]                   in_idx_ext;
  logic [CMP_W-1:0]                   in_lt_ext;
  logic [CMP_W-1:0]                   lt_ext;
  logic [CMP_W-1:0]                   rt_ext;
  logic [CMP_W-1:0]                   rtc;
  logic [CMP_W-1:0]                   len;
  logic [srm_pkg::LOG_W-1:0]          flog;
  logic [CMP_W-1:0]                   sec;
  logic [NXT_W-1:0]                   half;
  logic [NXT_W-1:0]                   nxt;
  logic signed [srm_pkg::VALUE_W-1:0] b_val;

  assign accept     = in_valid && !in_stall;
  assign in_idx_ext = CMP_W'(in_data.element_index);
  assign in_lt_ext  = CMP_W'(in_data.left_bound);
  assign lt_ext     = CMP_W'(lt_r);
  assign rt_ext     = CMP_W'(rt_r);
  assign half       = NXT_W'(1) << (lvl_r - LVL_W'(1));
  assign nxt        = NXT_W'(idx_r) + half;
  assign b_val      = b_oob_r ? srm_pkg::INT_MAX : mem_rd_data;
  assign res_data   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= srm_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r   <= lvl_nxt;
    idx_r   <= idx_nxt;
    lt_r    <= lt_nxt;
    rt_r    <= rt_nxt;
    rtc_r   <= rtc_nxt;
    sec_r   <= sec_nxt;
    a_r     <= a_nxt;
    b_oob_r <= b_oob_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    lvl_nxt      = lvl_r;
    idx_nxt      = idx_r;
    lt_nxt       = lt_r;
    rt_nxt       = rt_r;
    rtc_nxt      = rtc_r;
    sec_nxt      = sec_r;
    a_nxt        = a_r;
    b_oob_nxt    = b_oob_r;
    res_nxt      = res_r;
    in_stall     = 1'b1;
    res_valid    = 1'b0;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = '0;
    mem_wr_data  = srm_pkg::INT_MAX;
    mem_rd_addr  = '0;
    rtc          = '0;
    len          = '0;
    flog         = '0;
    sec          = '0;

    unique case (state_r)
      srm_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr_r;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = srm_pkg::ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end

      srm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          lt_nxt = in_data.left_bound;
          rt_nxt = in_data.right_bound;
          unique case (in_data.req_type)
            srm_pkg::REQ_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = srm_pkg::ST_CLEAR;
            end
            srm_pkg::REQ_LOAD: begin
              if (in_idx_ext < CMP_W'(NUM_ELEMENTS)) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = {LVL_W'(0), in_idx_ext[IDX_W-1:0]};
                mem_wr_data = in_data.element_value;
              end
            end
            srm_pkg::REQ_BUILD: begin
              lvl_nxt   = LVL_W'(1);
              idx_nxt   = '0;
              state_nxt = srm_pkg::ST_BLD_A;
            end
            srm_pkg::REQ_QUERY: begin
              if (in_data.left_bound > in_data.right_bound) begin
                res_nxt.min_value = '0;
                res_nxt.bad_range = 1'b1;
                state_nxt         = srm_pkg::ST_OUT;
              end else if (in_lt_ext >= CMP_W'(NUM_ELEMENTS)) begin
                res_nxt.min_value = srm_pkg::INT_MAX;
                res_nxt.bad_range = 1'b0;
                state_nxt         = srm_pkg::ST_OUT;
              end else begin
                state_nxt = srm_pkg::ST_Q_LVL;
              end
            end
            default: begin
              state_nxt = srm_pkg::ST_IDLE;
            end
          endcase
        end
      end

      srm_pkg::ST_BLD_A: begin
        mem_rd_addr = {lvl_r - LVL_W'(1), idx_r};
        state_nxt   = srm_pkg::ST_BLD_B;
      end

      srm_pkg::ST_BLD_B: begin
        a_nxt       = mem_rd_data;
        b_oob_nxt   = !(nxt < NXT_W'(NUM_ELEMENTS));
        mem_rd_addr = {lvl_r - LVL_W'(1), nxt[IDX_W-1:0]};
        state_nxt   = srm_pkg::ST_BLD_W;
      end

      srm_pkg::ST_BLD_W: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = {lvl_r, idx_r};
        mem_wr_data = (a_r < b_val) ? a_r : b_val;
        state_nxt   = srm_pkg::ST_BLD_A;
        if (idx_r == IDX_W'(NUM_ELEMENTS - 1)) begin
          idx_nxt = '0;
          if (lvl_r == LVL_W'(NUM_LEVELS - 1)) begin
            state_nxt = srm_pkg::ST_IDLE;
          end else begin
            lvl_nxt = lvl_r + LVL_W'(1);
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      srm_pkg::ST_Q_LVL: begin
        rtc  = (rt_ext >= CMP_W'(NUM_ELEMENTS)) ? CMP_W'(NUM_ELEMENTS - 1) : rt_ext;
        len  = rtc - lt_ext + CMP_W'(1);
        flog = srm_pkg::floor_log2_len(len[srm_pkg::LEN_W-1:0]);
        if (5'(flog) > 5'(NUM_LEVELS - 1)) begin
          lvl_nxt = LVL_W'(NUM_LEVELS - 1);
        end else begin
          lvl_nxt = LVL_W'(flog);
        end
        rtc_nxt   = rtc;
        state_nxt = srm_pkg::ST_Q_A;
      end

      srm_pkg::ST_Q_A: begin
        mem_rd_addr = {lvl_r, lt_ext[IDX_W-1:0]};
        sec         = rtc_r + CMP_W'(1) - (CMP_W'(1) << lvl_r);
        if (sec < lt_ext) begin
          sec = lt_ext;
        end
        sec_nxt   = sec[IDX_W-1:0];
        state_nxt = srm_pkg::ST_Q_B;
      end

      srm_pkg::ST_Q_B: begin
        mem_rd_addr = {lvl_r, sec_r};
        a_nxt       = mem_rd_data;
        state_nxt   = srm_pkg::ST_Q_MIN;
      end

      srm_pkg::ST_Q_MIN: begin
        res_nxt.min_value = (a_r < mem_rd_data) ? a_r : mem_rd_data;
        res_nxt.bad_range = 1'b0;
        state_nxt         = srm_pkg::ST_OUT;
      end

      srm_pkg::ST_OUT: begin
        res_valid = 1'b1;
        if (res_taken) begin
          state_nxt = srm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = srm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* tb/sv/tb_sparse_table_range_min_unit.sv */
// ----------------------------------------------------------------------------
// tb_sparse_table_range_min_unit: self-checking bench for the range minimum unit
// A queue of requests feeds a clocked driver that tracks the level table in a
// shadow copy and predicts each query answer; a clocked monitor compares every
// result with the oldest predicted answer, under random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sparse_table_range_min_unit;

  localparam int N_ELEM = srm_pkg::NUM_ELEMENTS_DEF;
  localparam int N_LVL  = srm_pkg::NUM_LEVELS_DEF;
  localparam logic signed [srm_pkg::VALUE_W-1:0] INT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic              pause;
    srm_pkg::in_item_t item;
  } stim_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  srm_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  srm_pkg::out_item_t out_data;

  stim_t              stim_queue[$];
  srm_pkg::out_item_t due_minima[$];
  logic signed [srm_pkg::VALUE_W-1:0] shadow_table [N_LVL][N_ELEM];

  int err_count    = 0;
  int n_accepted   = 0;
  int results_seen = 0;
  int n_loads      = 0;
  int n_builds     = 0;
  int n_clears     = 0;
  int n_queries    = 0;
  int n_inverted   = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;

  sparse_table_range_min_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The timeout lies well beyond the slowest correct run, including the
  // clearing sweep after reset, about ten builds and all stalls.
  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("%0t mismatch: %s got %h expected %h", $time, what, got, want);
  endtask

  task automatic fill_largest();
    for (int j = 0; j < N_LVL; j++) begin
      for (int i = 0; i < N_ELEM; i++) begin
        shadow_table[j][i] = srm_pkg::INT_MAX;
      end
    end
  endtask

  task automatic rebuild_levels();
    int half;
    logic signed [srm_pkg::VALUE_W-1:0] a;
    logic signed [srm_pkg::VALUE_W-1:0] b;
    for (int j = 1; j < N_LVL; j++) begin
      half = 1 << (j - 1);
      for (int i = 0; i < N_ELEM; i++) begin
        a = shadow_table[j-1][i];
        b = (i + half < N_ELEM) ? shadow_table[j-1][i+half] : srm_pkg::INT_MAX;
        shadow_table[j][i] = (a < b) ? a : b;
      end
    end
  endtask

  function automatic srm_pkg::out_item_t range_minimum(input srm_pkg::in_item_t r);
    srm_pkg::out_item_t res;
    int unsigned lt;
    int unsigned rt;
    int unsigned len;
    int unsigned lvl;
    int unsigned second;
    logic signed [srm_pkg::VALUE_W-1:0] a;
    logic signed [srm_pkg::VALUE_W-1:0] b;
    lt = r.left_bound;
    rt = r.right_bound;
    res = '0;
    if (lt > rt) begin
      res.bad_range = 1'b1;
    end else if (lt >= N_ELEM) begin
      res.min_value = srm_pkg::INT_MAX;
    end else begin
      if (rt >= N_ELEM) begin
        rt = N_ELEM - 1;
      end
      len = rt - lt + 1;
      lvl = 0;
      while (len > 1) begin
        len = len >> 1;
        lvl++;
      end
      if (lvl > N_LVL - 1) begin
        lvl = N_LVL - 1;
      end
      second = rt + 1 - (1 << lvl);
      if (second < lt) begin
        second = lt;
      end
      a = shadow_table[lvl][lt];
      b = shadow_table[lvl][second];
      res.min_value = (a < b) ? a : b;
    end
    return res;
  endfunction

  task automatic track_request(input srm_pkg::in_item_t r);
    n_accepted++;
    case (r.req_type)
      srm_pkg::REQ_CLEAR: begin
        n_clears++;
        fill_largest();
      end
      srm_pkg::REQ_LOAD: begin
        n_loads++;
        if (r.element_index < N_ELEM) begin
          shadow_table[0][r.element_index] = r.element_value;
        end
      end
      srm_pkg::REQ_BUILD: begin
        n_builds++;
        rebuild_levels();
      end
      default: begin
        n_queries++;
        if (r.left_bound > r.right_bound) begin
          n_inverted++;
        end
        due_minima.push_back(range_minimum(r));
      end
    endcase
  endtask

  task automatic check_result(input srm_pkg::out_item_t got);
    srm_pkg::out_item_t want;
    results_seen++;
    if (results_seen == 40 || results_seen == 700) begin
      hold_left = 300;
    end
    if (due_minima.size() == 0) begin
      report_mismatch("result with no query outstanding", got.min_value, '0);
    end else begin
      want = due_minima.pop_front();
      if (got.min_value !== want.min_value) begin
        report_mismatch("min_value", got.min_value, want.min_value);
      end
      if (got.bad_range !== want.bad_range) begin
        report_mismatch("bad_range", 32'(got.bad_range), 32'(want.bad_range));
      end
    end
  endtask

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((n_accepted / 100) % 3 == 0 || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic int next_stall();
    int r;
    r = $urandom_range(0, 99);
    if ((results_seen / 80) % 3 == 1 || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin : drive
    stim_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        track_request(in_data);
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (stim_queue.size() != 0 && stim_queue[0].pause) begin
        in_valid <= 1'b0;
        if (due_minima.size() == 0) begin
          void'(stim_queue.pop_front());
        end
      end else if (stim_queue.size() != 0) begin
        s = stim_queue.pop_front();
        in_data  <= s.item;
        in_valid <= 1'b1;
        gap_left = next_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = next_stall();
      end
    end
  end

  task automatic add_req(input srm_pkg::req_type_t kind, input int idx,
                         input logic [31:0] val, input int lt, input int rt);
    stim_t s;
    s.pause              = 1'b0;
    s.item.req_type      = kind;
    s.item.element_index = idx[srm_pkg::FIELD_IDX_W-1:0];
    s.item.element_value = val;
    s.item.left_bound    = lt[srm_pkg::FIELD_IDX_W-1:0];
    s.item.right_bound   = rt[srm_pkg::FIELD_IDX_W-1:0];
    stim_queue.push_back(s);
  endtask

  task automatic add_pause();
    stim_t s;
    s = '0;
    s.pause = 1'b1;
    stim_queue.push_back(s);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return INT_MIN;
    end
    if (r < 20) begin
      return srm_pkg::INT_MAX;
    end
    if (r < 30) begin
      return 32'($signed($urandom_range(0, 32)) - 16);
    end
    return $urandom();
  endfunction

  task automatic add_random_load();
    add_req(srm_pkg::REQ_LOAD, $urandom_range(0, 1023), pick_value(),
            $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  task automatic add_random_query();
    int r;
    int lt;
    int rt;
    int len;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      lt = $urandom_range(1, 1023);
      rt = $urandom_range(0, lt - 1);
    end else if (r < 35) begin
      lt = $urandom_range(0, 1023);
      rt = lt + $urandom_range(0, 7);
    end else if (r < 60) begin
      lt = $urandom_range(0, 1023);
      rt = $urandom_range(lt, 1023);
    end else if (r < 75) begin
      len = 1 << $urandom_range(0, 10);
      lt = $urandom_range(0, 1024 - len);
      rt = lt + len - 1;
    end else if (r < 88) begin
      rt = 1023;
      lt = $urandom_range(0, 1023);
    end else begin
      lt = 0;
      rt = $urandom_range(0, 1023);
    end
    if (rt > 1023) begin
      rt = 1023;
    end
    add_req(srm_pkg::REQ_QUERY, $urandom_range(0, 1023), $urandom(), lt, rt);
  endtask

  initial begin : main
    int n_fill;
    int n_ask;
    int r;

    add_req(srm_pkg::REQ_CLEAR, 0, 0, 0, 0);
    add_req(srm_pkg::REQ_LOAD, 0, INT_MIN, 0, 0);
    add_req(srm_pkg::REQ_LOAD, 1023, srm_pkg::INT_MAX, 0, 0);
    add_req(srm_pkg::REQ_LOAD, 512, 32'hFFFF_FFFF, 0, 0);
    add_req(srm_pkg::REQ_LOAD, 1, 32'h0, 0, 0);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 0, 0);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 0, 1);
    add_req(srm_pkg::REQ_BUILD, 0, 0, 0, 0);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 0, 1023);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 1, 1023);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 1023, 1023);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 1023, 0);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 5, 4);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 511, 513);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 513, 1023);
    add_req(srm_pkg::REQ_LOAD, 1022, 32'h8000_0001, 0, 0);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 1000, 1023);
    add_req(srm_pkg::REQ_BUILD, 0, 0, 0, 0);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 1000, 1023);
    add_req(srm_pkg::REQ_CLEAR, 0, 0, 0, 0);
    add_req(srm_pkg::REQ_QUERY, 0, 0, 0, 1023);
    add_pause();

    // Each round: optional clear, a batch of loads, a build, then queries
    // with a few loads mixed in so that some answers come from stale levels.
    for (int e = 0; e < 8; e++) begin
      if (e % 2 == 1) begin
        add_req(srm_pkg::REQ_CLEAR, $urandom_range(0, 1023), $urandom(),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      n_fill = $urandom_range(20, 60);
      for (int i = 0; i < n_fill; i++) begin
        add_random_load();
      end
      add_req(srm_pkg::REQ_BUILD, $urandom_range(0, 1023), $urandom(),
              $urandom_range(0, 1023), $urandom_range(0, 1023));
      n_ask = $urandom_range(100, 140);
      for (int i = 0; i < n_ask; i++) begin
        r = $urandom_range(0, 99);
        if (r < 90) begin
          add_random_query();
        end else begin
          add_random_load();
        end
      end
      if (e == 3) begin
        add_pause();
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_queue.size() != 0 || in_valid) begin
      @(negedge clk);
    end
    while (due_minima.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);

    $display("Run covered %0d requests: %0d loads, %0d builds, %0d clears,",
             n_accepted, n_loads, n_builds, n_clears);
    $display("and %0d range queries (%0d inverted), %0d results checked.",
             n_queries, n_inverted, results_seen);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/srm_pkg.sv
rtl/srm_level_mem.sv
rtl/srm_seq.sv
rtl/sparse_table_range_min_unit.sv
tb/sv/tb_sparse_table_range_min_unit.sv
